@@ hdl/rbsi_pkg.sv @@
// ----------------------------------------------------------------------------
// rbsi_pkg
// shared types, register indexes and fixed-point helpers for the ray/box
// slab intersection unit
// ----------------------------------------------------------------------------
package rbsi_pkg;

    localparam int unsigned WORD_W        = 32;
    localparam int unsigned NUM_AXES      = 3;
    localparam int unsigned CFG_IDX_W     = 3;
    localparam int unsigned FRAC_BITS_DEF = 16;
    localparam int unsigned PIPE_DEPTH    = 7;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_BOX_MIN_X = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_BOX_MIN_Y = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_BOX_MIN_Z = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_BOX_MAX_X = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_BOX_MAX_Y = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_BOX_MAX_Z = 3'd5;

    // entry face axis codes
    localparam logic [1:0] AXIS_X = 2'd0;
    localparam logic [1:0] AXIS_Y = 2'd1;
    localparam logic [1:0] AXIS_Z = 2'd2;

    typedef logic signed [WORD_W-1:0] t_word;

    typedef struct packed {
        t_word orig_x;
        t_word orig_y;
        t_word orig_z;
        t_word dir_x;
        t_word dir_y;
        t_word dir_z;
        t_word inv_dir_x;
        t_word inv_dir_y;
        t_word inv_dir_z;
        t_word t_low;
        t_word t_high;
    } t_ray_in;

    typedef struct packed {
        logic       hit;
        t_word      t_enter;
        logic [1:0] normal_axis;
        logic       normal_negative;
        t_word      point_x;
        t_word      point_y;
        t_word      point_z;
    } t_hit_out;

    // selection result handed from the compare stages to the hit point stages
    typedef struct packed {
        logic       hit;
        t_word      t_enter;
        logic [1:0] normal_axis;
        logic       normal_negative;
    } t_sel;

    // clamp a wide signed value to the 32-bit range
    function automatic t_word sat_word(input logic signed [64:0] v);
        logic signed [64:0] hi_lim;
        logic signed [64:0] lo_lim;
        hi_lim = 65'sd2147483647;
        lo_lim = -65'sd2147483648;
        if (v > hi_lim) begin
            sat_word = hi_lim[WORD_W-1:0];
        end else if (v < lo_lim) begin
            sat_word = lo_lim[WORD_W-1:0];
        end else begin
            sat_word = v[WORD_W-1:0];
        end
    endfunction

endpackage

@@ hdl/rbsi_slab.sv @@
// ----------------------------------------------------------------------------
// rbsi_slab
// three stages: box minus origin, product with inverse direction, then floor
// shift and saturation to the two slab distances of each axis
// ----------------------------------------------------------------------------
module rbsi_slab
    import rbsi_pkg::*;
#(
    parameter int unsigned FRAC_BITS = FRAC_BITS_DEF
) (
    input  logic        i_clk,
    input  logic [2:0]  i_en,
    input  t_ray_in     i_ray,
    input  t_word       i_box_lo [NUM_AXES],
    input  t_word       i_box_hi [NUM_AXES],
    output t_word       o_dist_lo [NUM_AXES],
    output t_word       o_dist_hi [NUM_AXES],
    output t_ray_in     o_ray
);

    t_word                    w_org [NUM_AXES];
    t_word                    w_inv [NUM_AXES];
    logic signed [WORD_W:0]   r_diff_lo [NUM_AXES];
    logic signed [WORD_W:0]   r_diff_hi [NUM_AXES];
    logic signed [64:0]       r_prod_lo [NUM_AXES];
    logic signed [64:0]       r_prod_hi [NUM_AXES];
    t_word                    r_dist_lo [NUM_AXES];
    t_word                    r_dist_hi [NUM_AXES];
    t_ray_in                  r_ray1;
    t_ray_in                  r_ray2;
    t_ray_in                  r_ray3;

    assign w_org[0] = i_ray.orig_x;
    assign w_org[1] = i_ray.orig_y;
    assign w_org[2] = i_ray.orig_z;
    assign w_inv[0] = r_ray1.inv_dir_x;
    assign w_inv[1] = r_ray1.inv_dir_y;
    assign w_inv[2] = r_ray1.inv_dir_z;

    // stage 1: exact 33-bit differences
    always_ff @(posedge i_clk) begin
        if (i_en[0]) begin
            r_ray1 <= i_ray;
            for (int i = 0; i < NUM_AXES; i++) begin
                r_diff_lo[i] <= {i_box_lo[i][WORD_W-1], i_box_lo[i]}
                              - {w_org[i][WORD_W-1], w_org[i]};
                r_diff_hi[i] <= {i_box_hi[i][WORD_W-1], i_box_hi[i]}
                              - {w_org[i][WORD_W-1], w_org[i]};
            end
        end
    end

    // stage 2: full products
    always_ff @(posedge i_clk) begin
        if (i_en[1]) begin
            r_ray2 <= r_ray1;
            for (int i = 0; i < NUM_AXES; i++) begin
                r_prod_lo[i] <= r_diff_lo[i] * w_inv[i];
                r_prod_hi[i] <= r_diff_hi[i] * w_inv[i];
            end
        end
    end

    // stage 3: floor shift and clamp
    always_ff @(posedge i_clk) begin
        if (i_en[2]) begin
            r_ray3 <= r_ray2;
            for (int i = 0; i < NUM_AXES; i++) begin
                r_dist_lo[i] <= sat_word(r_prod_lo[i] >>> FRAC_BITS);
                r_dist_hi[i] <= sat_word(r_prod_hi[i] >>> FRAC_BITS);
            end
        end
    end

    assign o_dist_lo = r_dist_lo;
    assign o_dist_hi = r_dist_hi;
    assign o_ray     = r_ray3;

endmodule

@@ hdl/rbsi_select.sv @@
// ----------------------------------------------------------------------------
// rbsi_select
// two stages: near/far ordering with entry and exit reduction, then the
// window test and entry face normal
// ----------------------------------------------------------------------------
module rbsi_select
    import rbsi_pkg::*;
(
    input  logic        i_clk,
    input  logic [1:0]  i_en,
    input  t_word       i_dist_lo [NUM_AXES],
    input  t_word       i_dist_hi [NUM_AXES],
    input  t_ray_in     i_ray,
    output t_sel        o_sel,
    output t_ray_in     o_ray
);

    t_word      w_inv [NUM_AXES];
    t_word      w_near [NUM_AXES];
    t_word      w_far [NUM_AXES];
    t_word      n_entry;
    t_word      n_exit;
    logic [1:0] n_axis;
    t_word      r_entry;
    t_word      r_exit;
    logic [1:0] r_axis;
    t_ray_in    r_ray4;
    t_sel       n_sel;
    t_sel       r_sel;
    t_ray_in    r_ray5;
    t_word      w_dir_a;
    t_word      w_inv_a;

    assign w_inv[0] = i_ray.inv_dir_x;
    assign w_inv[1] = i_ray.inv_dir_y;
    assign w_inv[2] = i_ray.inv_dir_z;

    // order each slab pair, then largest near and smallest far
    always_comb begin
        for (int i = 0; i < NUM_AXES; i++) begin
            if (w_inv[i][WORD_W-1]) begin
                w_near[i] = i_dist_hi[i];
                w_far[i]  = i_dist_lo[i];
            end else begin
                w_near[i] = i_dist_lo[i];
                w_far[i]  = i_dist_hi[i];
            end
        end
        n_entry = w_near[0];
        n_axis  = AXIS_X;
        n_exit  = w_far[0];
        if (w_near[1] > n_entry) begin
            n_entry = w_near[1];
            n_axis  = AXIS_Y;
        end
        if (w_near[2] > n_entry) begin
            n_entry = w_near[2];
            n_axis  = AXIS_Z;
        end
        if (w_far[1] < n_exit) begin
            n_exit = w_far[1];
        end
        if (w_far[2] < n_exit) begin
            n_exit = w_far[2];
        end
    end

    // stage 4
    always_ff @(posedge i_clk) begin
        if (i_en[0]) begin
            r_entry <= n_entry;
            r_exit  <= n_exit;
            r_axis  <= n_axis;
            r_ray4  <= i_ray;
        end
    end

    // direction components on the entry axis
    always_comb begin
        case (r_axis)
            AXIS_Y: begin
                w_dir_a = r_ray4.dir_y;
                w_inv_a = r_ray4.inv_dir_y;
            end
            AXIS_Z: begin
                w_dir_a = r_ray4.dir_z;
                w_inv_a = r_ray4.inv_dir_z;
            end
            default: begin
                w_dir_a = r_ray4.dir_x;
                w_inv_a = r_ray4.inv_dir_x;
            end
        endcase
    end

    // window test and face normal sign
    always_comb begin
        n_sel.hit = (r_entry <= r_exit) && (r_exit >= r_ray4.t_low)
                 && (r_entry <= r_ray4.t_high);
        n_sel.t_enter     = r_entry;
        n_sel.normal_axis = r_axis;
        if (w_dir_a != '0) begin
            n_sel.normal_negative = ~w_dir_a[WORD_W-1];
        end else begin
            n_sel.normal_negative = ~w_inv_a[WORD_W-1];
        end
    end

    // stage 5
    always_ff @(posedge i_clk) begin
        if (i_en[1]) begin
            r_sel  <= n_sel;
            r_ray5 <= r_ray4;
        end
    end

    assign o_sel = r_sel;
    assign o_ray = r_ray5;

endmodule

@@ hdl/rbsi_point.sv @@
// ----------------------------------------------------------------------------
// rbsi_point
// two stages: entry t times direction, then floor shift, clamp and origin add
// into the result beat
// ----------------------------------------------------------------------------
module rbsi_point
    import rbsi_pkg::*;
#(
    parameter int unsigned FRAC_BITS = FRAC_BITS_DEF
) (
    input  logic        i_clk,
    input  logic [1:0]  i_en,
    input  t_sel        i_sel,
    input  t_ray_in     i_ray,
    output t_hit_out    o_res
);

    t_word              w_dir [NUM_AXES];
    t_word              w_org [NUM_AXES];
    logic signed [63:0] r_prod [NUM_AXES];
    t_sel               r_sel;
    t_word              r_org [NUM_AXES];
    t_word              w_pt [NUM_AXES];
    t_word              w_step [NUM_AXES];
    logic signed [64:0] w_sum [NUM_AXES];
    t_hit_out           n_res;
    t_hit_out           r_res;

    assign w_dir[0] = i_ray.dir_x;
    assign w_dir[1] = i_ray.dir_y;
    assign w_dir[2] = i_ray.dir_z;
    assign w_org[0] = i_ray.orig_x;
    assign w_org[1] = i_ray.orig_y;
    assign w_org[2] = i_ray.orig_z;

    // stage 6: products
    always_ff @(posedge i_clk) begin
        if (i_en[0]) begin
            r_sel <= i_sel;
            for (int i = 0; i < NUM_AXES; i++) begin
                r_prod[i] <= i_sel.t_enter * w_dir[i];
                r_org[i]  <= w_org[i];
            end
        end
    end

    // scale, clamp, add origin and clamp again; a miss gives all zeros
    always_comb begin
        for (int i = 0; i < NUM_AXES; i++) begin
            w_step[i] = sat_word(65'(r_prod[i]) >>> FRAC_BITS);
            w_sum[i]  = 65'(r_org[i]) + 65'(w_step[i]);
            w_pt[i]   = sat_word(w_sum[i]);
        end
        n_res = '0;
        if (r_sel.hit) begin
            n_res.hit             = 1'b1;
            n_res.t_enter         = r_sel.t_enter;
            n_res.normal_axis     = r_sel.normal_axis;
            n_res.normal_negative = r_sel.normal_negative;
            n_res.point_x         = w_pt[0];
            n_res.point_y         = w_pt[1];
            n_res.point_z         = w_pt[2];
        end
    end

    // stage 7: output register
    always_ff @(posedge i_clk) begin
        if (i_en[1]) begin
            r_res <= n_res;
        end
    end

    assign o_res = r_res;

endmodule

@@ hdl/ray_box_slab_intersect_unit.sv @@
// ----------------------------------------------------------------------------
// ray_box_slab_intersect_unit
// ray against axis-aligned box, slab method, signed fixed point
// ----------------------------------------------------------------------------
// Usage:
//   in channel (i_in_valid / o_in_ready / i_in_data) takes one ray per beat:
//   origin, direction, inverse direction and the t window.
//   out channel (o_out_valid / i_out_ready / o_out_data) gives one result
//   beat per ray, in order: hit flag, entry t, entry face and hit point.
//   A miss returns hit low with every other field zero.
//   cfg channel (i_cfg_valid / o_cfg_ready / i_cfg_index / i_cfg_data)
//   writes the box corners, indexes 0..2 lower x/y/z, 3..5 upper x/y/z;
//   other indexes are dropped. It is always ready; write only when idle.
// Throughput: one ray per cycle while the receiver takes results, set by the
//   seven-stage pipeline (diff, slab multiply, clamp, reduce, window test,
//   point multiply, point).
// Reset: synchronous active low, empties the pipeline and sets the box to
//   lower corner 0 and upper corner 1.0 on every axis.
// Stall: when the receiver holds off, the last stage keeps its beat and
//   earlier stages keep filling bubbles; input ready drops only once every
//   stage holds a beat.
// ----------------------------------------------------------------------------
module ray_box_slab_intersect_unit
    import rbsi_pkg::*;
#(
    parameter int unsigned FRAC_BITS = FRAC_BITS_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_ready,
    input  t_ray_in              i_in_data,
    output logic                 o_out_valid,
    input  logic                 i_out_ready,
    output t_hit_out             o_out_data,
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  t_word                i_cfg_data
);

    localparam t_word BOX_HI_RESET = t_word'(64'sd1 <<< FRAC_BITS);

    logic [PIPE_DEPTH-1:0] r_valid;
    logic [PIPE_DEPTH-1:0] w_en;
    t_word                 r_box_lo [NUM_AXES];
    t_word                 r_box_hi [NUM_AXES];
    t_word                 w_dist_lo [NUM_AXES];
    t_word                 w_dist_hi [NUM_AXES];
    t_ray_in               w_ray3;
    t_ray_in               w_ray5;
    t_sel                  w_sel;

    // a stage advances when it is empty or the next one advances
    always_comb begin
        w_en[PIPE_DEPTH-1] = ~r_valid[PIPE_DEPTH-1] | i_out_ready;
        for (int k = PIPE_DEPTH - 2; k >= 0; k--) begin
            w_en[k] = ~r_valid[k] | w_en[k+1];
        end
    end

    assign o_in_ready  = w_en[0];
    assign o_out_valid = r_valid[PIPE_DEPTH-1];
    assign o_cfg_ready = 1'b1;

    // valid bits travel with the data
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else begin
            if (w_en[0]) begin
                r_valid[0] <= i_in_valid;
            end
            for (int k = 1; k < PIPE_DEPTH; k++) begin
                if (w_en[k]) begin
                    r_valid[k] <= r_valid[k-1];
                end
            end
        end
    end

    // box corner registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < NUM_AXES; i++) begin
                r_box_lo[i] <= '0;
                r_box_hi[i] <= BOX_HI_RESET;
            end
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_BOX_MIN_X: r_box_lo[0] <= i_cfg_data;
                CFG_BOX_MIN_Y: r_box_lo[1] <= i_cfg_data;
                CFG_BOX_MIN_Z: r_box_lo[2] <= i_cfg_data;
                CFG_BOX_MAX_X: r_box_hi[0] <= i_cfg_data;
                CFG_BOX_MAX_Y: r_box_hi[1] <= i_cfg_data;
                CFG_BOX_MAX_Z: r_box_hi[2] <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    // stages 1 to 3
    rbsi_slab #(
        .FRAC_BITS (FRAC_BITS)
    ) u_slab (
        .i_clk     (i_clk),
        .i_en      (w_en[2:0]),
        .i_ray     (i_in_data),
        .i_box_lo  (r_box_lo),
        .i_box_hi  (r_box_hi),
        .o_dist_lo (w_dist_lo),
        .o_dist_hi (w_dist_hi),
        .o_ray     (w_ray3)
    );

    // stages 4 and 5
    rbsi_select u_select (
        .i_clk     (i_clk),
        .i_en      (w_en[4:3]),
        .i_dist_lo (w_dist_lo),
        .i_dist_hi (w_dist_hi),
        .i_ray     (w_ray3),
        .o_sel     (w_sel),
        .o_ray     (w_ray5)
    );

    // stages 6 and 7
    rbsi_point #(
        .FRAC_BITS (FRAC_BITS)
    ) u_point (
        .i_clk (i_clk),
        .i_en  (w_en[6:5]),
        .i_sel (w_sel),
        .i_ray (w_ray5),
        .o_res (o_out_data)
    );

endmodule
